/* hdl/spq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 16;
  localparam int unsigned PRIO_W           = 16;
  localparam int unsigned TAG_W            = 16;
  localparam int unsigned COUNT_OUT_W      = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // One input transfer.
  typedef struct packed {
    logic             kind;
    logic [PRIO_W-1:0] priority_in;
    logic [TAG_W-1:0]  tag_in;
  } spq_cmd_t;

  // One result transfer.
  typedef struct packed {
    logic [PRIO_W-1:0]      head_priority;
    logic [TAG_W-1:0]       head_tag;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [1:0]             status;
  } spq_rsp_t;

  // One queue entry as held in a cell.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } spq_entry_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic       insert_en;
    logic       remove_en;
    spq_entry_t new_entry;
  } spq_ctrl_t;

  // What a cell shows its neighbors: keep goes to the right-hand one, the entry to both.
  typedef struct packed {
    logic       keep;
    spq_entry_t entry;
  } spq_link_t;

endpackage
`default_nettype wire

/* hdl/spq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: holds an entry and trades with its neighbors.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int unsigned IDX     = 0,
  parameter int unsigned COUNT_W = 5
) (
  input  wire logic               clk,
  input  wire spq_pkg::spq_ctrl_t ctrl,
  input  wire logic [COUNT_W-1:0] count,
  input  wire spq_pkg::spq_link_t left,
  input  wire spq_pkg::spq_entry_t right_entry,
  output spq_pkg::spq_link_t      link
);
  import spq_pkg::*;

  spq_entry_t entry;
  logic       occupied;
  logic       keep;

  // A slot is occupied when it sits below the fill count.
  assign occupied = (COUNT_W'(IDX) < count);
  // Stable insert: an entry with lower or equal priority stays in place.
  assign keep     = occupied && (entry.prio <= ctrl.new_entry.prio);

  assign link.keep  = keep;
  assign link.entry = entry;

  always_ff @(posedge clk) begin
    if (ctrl.insert_en) begin
      if (!keep) begin
        entry <= left.keep ? ctrl.new_entry : left.entry;
      end
    end else if (ctrl.remove_en) begin
      entry <= right_entry;
    end
  end

endmodule
`default_nettype wire

/* hdl/sorted_priority_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded min-first priority queue built as a row of sorting cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfer is taken at a rising edge where start is high and busy
//   is low. request.kind selects insert (priority_in, tag_in) or removal of
//   the head entry. busy stays low, so one command may be given every cycle.
//   Each command yields exactly one result transfer: done is high for one
//   cycle, the cycle right after the command edge, with the head entry, the
//   count held and a status. The receiver cannot hold results off; a result
//   is taken at the edge that ends its done cycle.
//   Throughput is one command per cycle. Every cell of the row compares its
//   own entry with the new priority and moves in the same cycle, so the
//   whole row updates in a single step.
//   Inserting into a full queue or removing from an empty queue leaves the
//   queue unchanged and reports STATUS_FULL or STATUS_EMPTY.
//   An empty queue reports a head priority and tag of zero.
//   Reset empties the queue by clearing the fill count; cell contents are
//   not cleared, since no cell at or above the count is ever shown.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire spq_pkg::spq_cmd_t request,
  output logic                   done,
  output spq_pkg::spq_rsp_t      result
);
  import spq_pkg::*;

  localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  status_t            status;
  status_t            status_next;
  logic               accept;
  logic               full;
  logic               empty;
  spq_ctrl_t          ctrl;
  spq_link_t          links [CAPACITY];

  // The whole row updates at once, so the block is always ready.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == COUNT_W'(CAPACITY));
  assign empty  = (count == '0);

  // Decide the operation and the count after it.
  always_comb begin
    ctrl.new_entry.prio = request.priority_in;
    ctrl.new_entry.tag  = request.tag_in;
    ctrl.insert_en      = 1'b0;
    ctrl.remove_en      = 1'b0;
    count_next          = count;
    status_next         = STATUS_OK;
    if (accept) begin
      if (request.kind == KIND_INSERT) begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          ctrl.insert_en = 1'b1;
          count_next     = count + 1'b1;
        end
      end else begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          ctrl.remove_en = 1'b1;
          count_next     = count - 1'b1;
        end
      end
    end
  end

  // The row of cells. Cell 0 sees a left neighbor that always keeps, so a
  // new entry that goes ahead of everything lands at the head. The last
  // cell pulls in an unused entry on removal; it is then beyond the count.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_link_t  left;
    spq_entry_t right_entry;

    if (i == 0) begin : g_head
      assign left.keep  = 1'b1;
      assign left.entry = links[0].entry;
    end else begin : g_body
      assign left = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = links[i].entry;
    end else begin : g_inner
      assign right_entry = links[i+1].entry;
    end

    spq_cell #(
      .IDX     (i),
      .COUNT_W (COUNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .left        (left),
      .right_entry (right_entry),
      .link        (links[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      done   <= 1'b0;
      status <= STATUS_OK;
    end else begin
      count <= count_next;
      done  <= accept;
      if (accept) begin
        status <= status_next;
      end
    end
  end

  // The result reads straight from the head cell after the update.
  always_comb begin
    result.head_priority = empty ? '0 : links[0].entry.prio;
    result.head_tag      = empty ? '0 : links[0].entry.tag;
    result.entry_count   = COUNT_OUT_W'(count);
    result.status        = status;
  end

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  // Every accepted command gives a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted command gave no result");

  // A refused insert leaves a full queue; a refused removal an empty one.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_FULL) |-> full)
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_EMPTY) |-> empty)
    else $error("empty status with entries held");

  // A successful insert or removal must change the count; the decode above steps it by exactly one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (accept && status_next == STATUS_OK) |=> (count != $past(count)))
    else $error("count did not move on a successful command");

endmodule
`default_nettype wire
